>>> design/assert_macros.svh
// Assertion macros used by the horizon occlusion buffer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define HOB_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HOB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/hob_pkg.sv
// Shared types and constants of the horizon occlusion buffer.
package hob_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CULL_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERRAIN_Z = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y    = 3'd6;

  // Request types.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_TEST  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Result selection.
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_NEAR = 2'd1;
  localparam logic [1:0] RES_OCC  = 2'd2;

  // Division operand selection.
  localparam logic [1:0] DIV_SCREEN = 2'd0;
  localparam logic [1:0] DIV_LOW    = 2'd1;
  localparam logic [1:0] DIV_HIGH   = 2'd2;

  // Corner product order: fx*py, fy*px, fx*px, fy*py.
  localparam logic [1:0] MUL_FX_PY = 2'd0;
  localparam logic [1:0] MUL_FY_PX = 2'd1;
  localparam logic [1:0] MUL_FX_PX = 2'd2;
  localparam logic [1:0] MUL_FY_PY = 2'd3;

  // Screen mapping steps.
  localparam logic [1:0] MAP_T_LO = 2'd0;
  localparam logic [1:0] MAP_T_HI = 2'd1;
  localparam logic [1:0] MAP_U_LO = 2'd2;
  localparam logic [1:0] MAP_U_HI = 2'd3;

  // Fixed-point constants.
  localparam logic signed [15:0] SCREEN_SCALE = 16'sd21627;
  localparam logic signed [31:0] SCREEN_HALF  = 32'sd32768;
  localparam logic signed [31:0] S32_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX      = 32'sh7fff_ffff;
  localparam logic signed [31:0] SLOPE_MIN    = 32'sh8000_0001;

  // Divider widths.
  localparam int unsigned NUM_W = 52;
  localparam int unsigned DEN_W = 36;
  localparam int unsigned QUO_W = 32;
  localparam int unsigned RES_W = 34;

  // Item widths on the stream ports.
  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap_en;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic [1:0] corner;
    logic       div_start;
    logic [1:0] div_sel;
    logic       take_en;
    logic       first;
    logic       map_en;
    logic [1:0] map_sel;
    logic       span_init;
    logic       span_upd;
    logic       idx_clr;
    logic       idx_inc;
    logic       scan_cmp;
    logic       upd_wr;
    logic       clr_wr;
    logic       res_load;
    logic [1:0] res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req;
    logic       cull_off;
    logic       d_pos;
    logic       div_done;
    logic       scan_ne;
    logic       upd_ne;
    logic       idx_last;
    logic       idx_max;
    logic       occ;
    logic       above;
  } status_t;

endpackage

>>> design/hob_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hob_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/hob_div.sv
// Bit-serial signed floor divider with saturation flag, one quotient bit a cycle.
module hob_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [hob_pkg::NUM_W-1:0]    num,
  input  logic        [hob_pkg::DEN_W-1:0]    den,
  output logic                                done,
  output logic signed [hob_pkg::RES_W-1:0]    quo
);

  localparam int unsigned NW = hob_pkg::NUM_W;
  localparam int unsigned DW = hob_pkg::DEN_W;
  localparam int unsigned QW = hob_pkg::QUO_W;
  localparam int unsigned RW = hob_pkg::RES_W;
  localparam int unsigned CW = $clog2(QW);

  logic          busy;
  logic          fin;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          ovf;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem;
  logic [QW-1:0] low;

  logic [NW-1:0] mag;
  logic [DW:0]   trial;
  logic          ge;
  logic [RW-1:0] qext;

  // Magnitude of the dividend and one restoring step.
  assign mag   = num[NW-1] ? (~num + NW'(1)) : num;
  assign trial = {rem, low[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign qext  = {{(RW-QW){1'b0}}, low} + {{(RW-1){1'b0}}, rem != '0};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW-1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NW-1];
      ovf   <= {{(DW-(NW-QW)){1'b0}}, mag[NW-1:QW]} >= den;
      den_q <= den;
      rem   <= {{(DW-(NW-QW)){1'b0}}, mag[NW-1:QW]};
      low   <= mag[QW-1:0];
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      low <= {low[QW-2:0], ge};
    end
  end

  // Signed floor result; a quotient of 2^32 or more saturates.
  always_ff @(posedge clk) begin
    if (fin) begin
      if (ovf) begin
        quo <= neg ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
      end else if (neg) begin
        quo <= -$signed(qext);
      end else begin
        quo <= $signed({{(RW-QW){1'b0}}, low});
      end
    end
  end

endmodule

>>> design/hob_datapath.sv
// Datapath: registers, corner transform, divider, screen mapping and horizon memory.
module hob_datapath #(
  parameter int unsigned HORIZON_ENTRIES = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hob_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic [hob_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                       s_tuser,
  input  hob_pkg::cmd_t                    cmd,
  output hob_pkg::status_t                 stat,
  output logic [hob_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int unsigned IW = $clog2(HORIZON_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(HORIZON_ENTRIES - 1);
  localparam logic signed [32:0] LIMIT = $signed({1'b0, 32'(HORIZON_ENTRIES - 1)});
  localparam logic signed [15:0] ENTRIES16 = 16'(HORIZON_ENTRIES);

  // Configuration registers.
  logic               cull_en;
  logic signed [31:0] terrain_z;
  logic signed [31:0] cam_x;
  logic signed [31:0] cam_y;
  logic signed [31:0] cam_z;
  logic signed [15:0] vdx;
  logic signed [15:0] vdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cull_en   <= 1'b1;
      terrain_z <= '0;
      cam_x     <= '0;
      cam_y     <= '0;
      cam_z     <= '0;
      vdx       <= '0;
      vdy       <= 16'sd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        hob_pkg::CFG_CULL_EN:   cull_en   <= cfg_data[0];
        hob_pkg::CFG_TERRAIN_Z: terrain_z <= cfg_data;
        hob_pkg::CFG_CAM_X:     cam_x     <= cfg_data;
        hob_pkg::CFG_CAM_Y:     cam_y     <= cfg_data;
        hob_pkg::CFG_CAM_Z:     cam_z     <= cfg_data;
        hob_pkg::CFG_VIEW_X:    vdx       <= cfg_data[15:0];
        hob_pkg::CFG_VIEW_Y:    vdy       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [1:0]         req;
  logic signed [31:0] bx0;
  logic signed [31:0] bx1;
  logic signed [31:0] by0;
  logic signed [31:0] by1;
  logic signed [31:0] zmin;
  logic signed [31:0] zmax;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      req  <= s_tuser;
      bx0  <= s_tdata[31:0];
      bx1  <= s_tdata[63:32];
      by0  <= s_tdata[95:64];
      by1  <= s_tdata[127:96];
      zmin <= s_tdata[159:128];
      zmax <= s_tdata[191:160];
    end
  end

  // Corner offsets from the camera.
  logic signed [31:0] bx_sel;
  logic signed [31:0] by_sel;
  logic signed [32:0] px;
  logic signed [32:0] py;
  logic signed [32:0] dz_min;
  logic signed [32:0] dz_max;

  assign bx_sel = cmd.corner[1] ? bx1 : bx0;
  assign by_sel = cmd.corner[0] ? by1 : by0;
  assign px     = $signed({bx_sel[31], bx_sel}) - $signed({cam_x[31], cam_x});
  assign py     = $signed({by_sel[31], by_sel}) - $signed({cam_y[31], cam_y});
  assign dz_min = $signed({zmin[31], zmin}) - $signed({cam_z[31], cam_z});
  assign dz_max = $signed({zmax[31], zmax}) - $signed({cam_z[31], cam_z});

  // Shared corner multiplier, one product a cycle.
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [48:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      hob_pkg::MUL_FX_PY: begin mul_a = vdx; mul_b = py; end
      hob_pkg::MUL_FY_PX: begin mul_a = vdy; mul_b = px; end
      hob_pkg::MUL_FX_PX: begin mul_a = vdx; mul_b = px; end
      default:            begin mul_a = vdy; mul_b = py; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Lateral offset and depth accumulate from the products.
  logic signed [49:0] lx_acc;
  logic signed [49:0] d_acc;
  logic signed [49:0] prod_ext;
  logic signed [35:0] lx_fl;
  logic signed [35:0] d_fl;

  assign prod_ext = $signed({prod[48], prod});

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      case (cmd.acc_sel)
        hob_pkg::MUL_FX_PY: lx_acc <= prod_ext;
        hob_pkg::MUL_FY_PX: lx_acc <= lx_acc - prod_ext;
        hob_pkg::MUL_FX_PX: d_acc  <= prod_ext;
        default:            d_acc  <= d_acc + prod_ext;
      endcase
    end
  end

  assign lx_fl = $signed(lx_acc[49:14]);
  assign d_fl  = $signed(d_acc[49:14]);

  // Divider operands.
  logic signed [hob_pkg::NUM_W-1:0] div_num;
  logic        [hob_pkg::DEN_W-1:0] div_den;
  logic                              div_done;
  logic signed [hob_pkg::RES_W-1:0] div_quo;

  always_comb begin
    case (cmd.div_sel)
      hob_pkg::DIV_SCREEN: div_num = $signed({lx_fl, 16'h0000});
      hob_pkg::DIV_LOW:    div_num = $signed({{3{dz_min[32]}}, dz_min, 16'h0000});
      default:             div_num = $signed({{3{dz_max[32]}}, dz_max, 16'h0000});
    endcase
  end

  assign div_den = d_fl;

  hob_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Saturate the quotient to 32 bits; height slopes stay off the most negative code.
  logic signed [31:0] s_cl;
  logic signed [31:0] h_cl;

  always_comb begin
    if (div_quo[33:31] == 3'b000 || div_quo[33:31] == 3'b111) begin
      s_cl = div_quo[31:0];
    end else if (div_quo[33]) begin
      s_cl = hob_pkg::S32_MIN;
    end else begin
      s_cl = hob_pkg::S32_MAX;
    end
  end

  assign h_cl = (s_cl == hob_pkg::S32_MIN) ? hob_pkg::SLOPE_MIN : s_cl;

  // Running extremes over the corners.
  logic signed [31:0] smin;
  logic signed [31:0] smax;
  logic signed [31:0] hmin;
  logic signed [31:0] hmax;

  always_ff @(posedge clk) begin
    if (cmd.take_en) begin
      case (cmd.div_sel)
        hob_pkg::DIV_SCREEN: begin
          if (cmd.first || s_cl < smin) smin <= s_cl;
          if (cmd.first || s_cl > smax) smax <= s_cl;
        end
        hob_pkg::DIV_LOW: begin
          if (cmd.first || h_cl < hmin) hmin <= h_cl;
        end
        default: begin
          if (cmd.first || h_cl > hmax) hmax <= h_cl;
        end
      endcase
    end
  end

  // Screen mapping, one multiply a step.
  logic signed [31:0] map_a;
  logic signed [15:0] map_b;
  logic signed [47:0] map_p;
  logic signed [31:0] ta;
  logic signed [31:0] tb;
  logic signed [47:0] ulo;
  logic signed [47:0] uhi;

  always_comb begin
    case (cmd.map_sel)
      hob_pkg::MAP_T_LO: begin map_a = smin; map_b = hob_pkg::SCREEN_SCALE; end
      hob_pkg::MAP_T_HI: begin map_a = smax; map_b = hob_pkg::SCREEN_SCALE; end
      hob_pkg::MAP_U_LO: begin map_a = ta;   map_b = ENTRIES16; end
      default:           begin map_a = tb;   map_b = ENTRIES16; end
    endcase
  end

  assign map_p = map_a * map_b;

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      case (cmd.map_sel)
        hob_pkg::MAP_T_LO: ta  <= $signed(map_p[47:16]) + hob_pkg::SCREEN_HALF;
        hob_pkg::MAP_T_HI: tb  <= $signed(map_p[47:16]) + hob_pkg::SCREEN_HALF;
        hob_pkg::MAP_U_LO: ulo <= map_p;
        default:           uhi <= map_p;
      endcase
    end
  end

  // Floor and ceiling of the entry positions.
  logic signed [48:0] ulo_up;
  logic signed [48:0] uhi_up;
  logic signed [32:0] lo_f;
  logic signed [32:0] lo_c;
  logic signed [32:0] hi_f;
  logic signed [32:0] hi_c;
  logic signed [32:0] scan_lo;
  logic signed [32:0] scan_hi;
  logic signed [32:0] upd_lo;
  logic signed [32:0] upd_hi;
  logic               scan_ne;
  logic               upd_ne;

  assign ulo_up  = $signed({ulo[47], ulo}) + 49'sd65535;
  assign uhi_up  = $signed({uhi[47], uhi}) + 49'sd65535;
  assign lo_f    = $signed({ulo[47], ulo[47:16]});
  assign hi_f    = $signed({uhi[47], uhi[47:16]});
  assign lo_c    = $signed(ulo_up[48:16]);
  assign hi_c    = $signed(uhi_up[48:16]);
  assign scan_lo = lo_f[32] ? '0 : lo_f;
  assign scan_hi = (hi_c > LIMIT) ? LIMIT : hi_c;
  assign upd_lo  = lo_c[32] ? '0 : lo_c;
  assign upd_hi  = (hi_f > LIMIT) ? LIMIT : hi_f;
  assign scan_ne = scan_hi >= scan_lo;
  assign upd_ne  = upd_hi >= upd_lo;

  // Entry index and span bound.
  logic [IW-1:0] idx;
  logic [IW-1:0] hi_idx;
  logic          occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.span_init) begin
      idx <= cmd.span_upd ? upd_lo[IW-1:0] : scan_lo[IW-1:0];
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.span_init) begin
      hi_idx <= cmd.span_upd ? upd_hi[IW-1:0] : scan_hi[IW-1:0];
    end
  end

  // Horizon memory.
  logic               ram_we;
  logic signed [31:0] ram_wdata;
  logic signed [31:0] ram_rdata;
  logic               above;
  logic               raise;

  assign above     = hmax > ram_rdata;
  assign raise     = hmin > ram_rdata;
  assign ram_we    = cmd.clr_wr || (cmd.upd_wr && raise);
  assign ram_wdata = cmd.clr_wr ? hob_pkg::S32_MIN : hmin;

  hob_ram #(
    .WIDTH (32),
    .DEPTH (HORIZON_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Occlusion flag over the scan.
  always_ff @(posedge clk) begin
    if (cmd.span_init && !cmd.span_upd) begin
      occ <= scan_ne;
    end else if (cmd.scan_cmp && above) begin
      occ <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        hob_pkg::RES_NEAR: m_tdata <= 8'h02;
        hob_pkg::RES_OCC:  m_tdata <= {7'h00, occ};
        default:           m_tdata <= 8'h00;
      endcase
    end
  end

  // Status to the controller.
  always_comb begin
    stat.req      = req;
    stat.cull_off = !cull_en || (cam_z > terrain_z);
    stat.d_pos    = !d_fl[35] && (d_fl != '0);
    stat.div_done = div_done;
    stat.scan_ne  = scan_ne;
    stat.upd_ne   = upd_ne;
    stat.idx_last = idx == hi_idx;
    stat.idx_max  = idx == LAST_IDX;
    stat.occ      = occ;
    stat.above    = above;
  end

endmodule

>>> design/hob_ctrl.sv
// Controller: sequences one item through the datapath and owns the stream handshake.
`include "assert_macros.svh"

module hob_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  hob_pkg::status_t stat,
  output hob_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_INIT_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DISPATCH  = 5'd2;
  localparam logic [4:0] S_CLR       = 5'd3;
  localparam logic [4:0] S_MUL       = 5'd4;
  localparam logic [4:0] S_CHK       = 5'd5;
  localparam logic [4:0] S_DIV_GO    = 5'd6;
  localparam logic [4:0] S_DIV_WAIT  = 5'd7;
  localparam logic [4:0] S_MAP       = 5'd8;
  localparam logic [4:0] S_SCAN_INIT = 5'd9;
  localparam logic [4:0] S_SCAN_RD   = 5'd10;
  localparam logic [4:0] S_SCAN_CMP  = 5'd11;
  localparam logic [4:0] S_POST      = 5'd12;
  localparam logic [4:0] S_UPD_INIT  = 5'd13;
  localparam logic [4:0] S_UPD_RD    = 5'd14;
  localparam logic [4:0] S_UPD_WR    = 5'd15;
  localparam logic [4:0] S_FIN       = 5'd16;

  localparam logic [2:0] MUL_STEPS = 3'd4;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] corner;
  logic [1:0] corner_next;
  logic [2:0] step;
  logic [2:0] step_next;
  logic [1:0] dsel;
  logic [1:0] dsel_next;
  logic [1:0] mstep;
  logic [1:0] mstep_next;
  logic [1:0] res_sel;
  logic [1:0] res_sel_next;
  logic       m_tvalid_next;

  assign s_tready = state == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_next    = state;
    corner_next   = corner;
    step_next     = step;
    dsel_next     = dsel;
    mstep_next    = mstep;
    res_sel_next  = res_sel;
    m_tvalid_next = m_tvalid && !m_tready;
    cmd           = '0;
    cmd.corner    = corner;
    cmd.mul_sel   = step[1:0];
    cmd.acc_sel   = 2'(step - 3'd1);
    cmd.div_sel   = dsel;
    cmd.map_sel   = mstep;
    cmd.res_sel   = res_sel;

    case (state)
      S_INIT_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_max) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.cap_en = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.req == hob_pkg::REQ_CLEAR) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_CLR;
        end else if (stat.req == hob_pkg::REQ_NONE || stat.cull_off) begin
          res_sel_next = hob_pkg::RES_ZERO;
          state_next   = S_FIN;
        end else begin
          corner_next = 2'd0;
          step_next   = 3'd0;
          state_next  = S_MUL;
        end
      end
      S_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_max) begin
          res_sel_next = hob_pkg::RES_ZERO;
          state_next   = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul_en = step != MUL_STEPS;
        cmd.acc_en = step != 3'd0;
        step_next  = step + 3'd1;
        if (step == MUL_STEPS) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat.d_pos) begin
          res_sel_next = hob_pkg::RES_NEAR;
          state_next   = S_FIN;
        end else begin
          dsel_next  = hob_pkg::DIV_SCREEN;
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.take_en = 1'b1;
          cmd.first   = corner == 2'd0;
          if (dsel == hob_pkg::DIV_HIGH) begin
            if (corner == 2'd3) begin
              mstep_next = hob_pkg::MAP_T_LO;
              state_next = S_MAP;
            end else begin
              corner_next = corner + 2'd1;
              step_next   = 3'd0;
              state_next  = S_MUL;
            end
          end else begin
            dsel_next  = dsel + 2'd1;
            state_next = S_DIV_GO;
          end
        end
      end
      S_MAP: begin
        cmd.map_en = 1'b1;
        mstep_next = mstep + 2'd1;
        if (mstep == hob_pkg::MAP_U_HI) begin
          state_next = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.span_init = 1'b1;
        state_next    = stat.scan_ne ? S_SCAN_RD : S_POST;
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (stat.above || stat.idx_last) begin
          state_next = S_POST;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_POST: begin
        res_sel_next = hob_pkg::RES_OCC;
        if (stat.req == hob_pkg::REQ_ADD && !stat.occ) begin
          state_next = S_UPD_INIT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_UPD_INIT: begin
        cmd.span_init = 1'b1;
        cmd.span_upd  = 1'b1;
        state_next    = stat.upd_ne ? S_UPD_RD : S_FIN;
      end
      S_UPD_RD: begin
        state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        if (stat.idx_last) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_UPD_RD;
        end
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.res_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT_CLR;
      corner   <= '0;
      step     <= '0;
      dsel     <= '0;
      mstep    <= '0;
      res_sel  <= hob_pkg::RES_ZERO;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      corner   <= corner_next;
      step     <= step_next;
      dsel     <= dsel_next;
      mstep    <= mstep_next;
      res_sel  <= res_sel_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Only one item is in work at a time.
  `HOB_ASSERT_CLK(a_one_item, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
  // A waiting result is never overwritten.
  `HOB_ASSERT_CLK(a_no_overwrite, cmd.res_load |-> (!m_tvalid || m_tready), "result overwritten")
  // Reset starts the clearing pass with input closed.
  `HOB_ASSERT_RST(a_reset_sweep, rst |=> (!s_tready && !m_tvalid), "input open after reset")

endmodule

>>> design/horizon_occlusion_buffer_core.sv
// Horizon occlusion buffer: top level joining controller and datapath.
// Per item: a clear writes every horizon entry; a test or an add runs, for each of the four
// corners, five multiply steps, a depth check and three divisions, then maps the span and
// reads and compares each scanned entry; an add then reads and writes each updated entry.
// One item is in work at a time; the next item is taken the cycle after a result is loaded.
// Reset (synchronous, rst high) is followed by a clearing pass over all HORIZON_ENTRIES entries.
module horizon_occlusion_buffer_core #(
  parameter int unsigned HORIZON_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0: box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max.
  input  logic [hob_pkg::IN_DATA_W-1:0] s_tdata,
  // Fields from bit 0: req_type.
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: occluded, near_rejected, zero fill.
  output logic [hob_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic [hob_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  hob_pkg::cmd_t    cmd;
  hob_pkg::status_t stat;

  // Sequencer.
  hob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and horizon memory.
  hob_datapath #(
    .HORIZON_ENTRIES (HORIZON_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata)
  );

endmodule
